// ===== hw/rtl/ftm_pkg.sv =====
// Shared types and constants for the frame-to-millisecond mapper.
// Used by the shared arithmetic unit, the conversion sequencer and the top level.
// No dependencies.
package ftm_pkg;

  // Field widths.
  localparam int unsigned FRAME_W = 32;
  localparam int unsigned MS_W    = 63;
  localparam int unsigned REQ_W   = 64;
  localparam int unsigned CFG_W   = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // Datapath width of the shared adder: wide enough for 2*acc + prod.
  localparam int unsigned ALU_W = 66;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_FRAME = 2'd2;

  // Operations of the shared adder.
  typedef enum logic {
    ALU_ADD = 1'b0,
    ALU_SUB = 1'b1
  } alu_op_t;

  // Result of one frame-time conversion.
  typedef struct packed {
    logic [MS_W-1:0] ms;
    logic            ok;
  } conv_result_t;

endpackage

// ===== hw/rtl/ftm_alu.sv =====
// Shared add/subtract unit of the mapper.
// Serves the gcd loop, the shift-add multiplier and the restoring divider.
// Depends on ftm_pkg.
module ftm_alu (
  input  ftm_pkg::alu_op_t           op,
  input  logic [ftm_pkg::ALU_W-1:0]  x,
  input  logic [ftm_pkg::ALU_W-1:0]  y,
  output logic [ftm_pkg::ALU_W-1:0]  result,
  output logic                       carry
);
  import ftm_pkg::*;

  logic              sub;
  logic [ALU_W-1:0]  y_eff;
  logic [ALU_W:0]    sum;

  // For a subtract, carry out high means x >= y.
  assign sub    = (op == ALU_SUB);
  assign y_eff  = sub ? ~y : y;
  assign sum    = {1'b0, x} + {1'b0, y_eff} + {{ALU_W{1'b0}}, sub};
  assign result = sum[ALU_W-1:0];
  assign carry  = sum[ALU_W];

endmodule

// ===== hw/rtl/ftm_conv.sv =====
// Sequencer for one frame-time conversion: binary gcd reductions, checked
// shift-add multiplies and a restoring division, all on the shared adder.
// Depends on ftm_pkg and ftm_alu.
module ftm_conv #(
  parameter int unsigned TIME_SCALE = 1000
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ftm_pkg::FRAME_W-1:0]   frame,
  input  logic [ftm_pkg::CFG_W-1:0]     rate_num,
  input  logic [ftm_pkg::CFG_W-1:0]     rate_den,
  output logic                          done,
  output ftm_pkg::conv_result_t         result
);
  import ftm_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b00_0000_0001,
    S_GSTART = 10'b00_0000_0010,
    S_GSTRIP = 10'b00_0000_0100,
    S_GLOOP  = 10'b00_0000_1000,
    S_DIVF   = 10'b00_0001_0000,
    S_DIVD   = 10'b00_0010_0000,
    S_MSTART = 10'b00_0100_0000,
    S_MUL    = 10'b00_1000_0000,
    S_DIVP   = 10'b01_0000_0000,
    S_DONE   = 10'b10_0000_0000
  } conv_state_t;

  conv_state_t          state;
  logic [FRAME_W-1:0]   fac [3];
  logic [1:0]           idx;
  logic [FRAME_W-1:0]   dv;
  logic [FRAME_W-1:0]   ga;
  logic [FRAME_W-1:0]   gb;
  logic [4:0]           gk;
  logic [FRAME_W-1:0]   dvsr;
  logic [FRAME_W-1:0]   rem;
  logic [FRAME_W-1:0]   mreg;
  logic [MS_W-1:0]      q;
  logic [MS_W-1:0]      prod;
  logic [MS_W-1:0]      acc;
  logic [5:0]           cnt;
  conv_result_t         res;

  alu_op_t              alu_op;
  logic [ALU_W-1:0]     alu_x;
  logic [ALU_W-1:0]     alu_y;
  logic [ALU_W-1:0]     alu_r;
  logic                 alu_c;
  logic                 alu_zero;

  logic [FRAME_W-1:0]   fac_cur;
  logic [MS_W-1:0]      q_next;
  logic [FRAME_W-1:0]   rem_next;
  logic                 mul_ovf;

  ftm_alu u_alu (
    .op     (alu_op),
    .x      (alu_x),
    .y      (alu_y),
    .result (alu_r),
    .carry  (alu_c)
  );

  assign fac_cur  = fac[idx];
  assign alu_zero = (alu_r == '0);

  // One restoring division step: trial subtract of the shifted remainder.
  assign q_next   = {q[MS_W-2:0], alu_c};
  assign rem_next = alu_c ? alu_r[FRAME_W-1:0] : {rem[FRAME_W-2:0], q[MS_W-1]};

  // A partial product above the signed 64-bit maximum is an overflow.
  assign mul_ovf  = (alu_r[ALU_W-1:MS_W] != '0);

  // Operand selection for the shared adder.
  always_comb begin
    alu_op = ALU_ADD;
    alu_x  = '0;
    alu_y  = '0;
    unique case (state)
      S_GLOOP: begin
        alu_op = ALU_SUB;
        alu_x  = {{(ALU_W-FRAME_W){1'b0}}, ga};
        alu_y  = {{(ALU_W-FRAME_W){1'b0}}, gb};
      end
      S_DIVF, S_DIVD, S_DIVP: begin
        alu_op = ALU_SUB;
        alu_x  = {{(ALU_W-FRAME_W-1){1'b0}}, rem, q[MS_W-1]};
        alu_y  = {{(ALU_W-FRAME_W){1'b0}}, dvsr};
      end
      S_MUL: begin
        alu_op = ALU_ADD;
        alu_x  = {{(ALU_W-MS_W-1){1'b0}}, acc, 1'b0};
        alu_y  = mreg[FRAME_W-1] ? {{(ALU_W-MS_W){1'b0}}, prod} : '0;
      end
      default: begin
        alu_op = ALU_ADD;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (rate_num == '0 || rate_den == '0) begin
              state <= S_DONE;
            end else begin
              state <= S_GSTART;
            end
          end
        end
        S_GSTART: state <= S_GSTRIP;
        S_GSTRIP: begin
          if (ga[0] || gb[0]) begin
            state <= S_GLOOP;
          end
        end
        S_GLOOP: begin
          if (ga[0] && gb[0] && alu_zero) begin
            state <= S_DIVF;
          end
        end
        S_DIVF: begin
          if (cnt == 6'd1) begin
            state <= S_DIVD;
          end
        end
        S_DIVD: begin
          if (cnt == 6'd1) begin
            state <= (idx == 2'd2) ? S_MSTART : S_GSTART;
          end
        end
        S_MSTART: state <= S_MUL;
        S_MUL: begin
          if (mul_ovf) begin
            state <= S_DONE;
          end else if (cnt == 6'd1) begin
            state <= (idx == 2'd2) ? S_DIVP : S_MSTART;
          end
        end
        S_DIVP: begin
          if (cnt == 6'd1) begin
            state <= S_DONE;
          end
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (start) begin
          res    <= '0;
          fac[0] <= frame;
          fac[1] <= rate_den;
          fac[2] <= FRAME_W'(TIME_SCALE);
          dv     <= rate_num;
          idx    <= 2'd0;
        end
      end
      // A zero factor has gcd equal to the divisor, as does the divisor with itself.
      S_GSTART: begin
        ga <= (fac_cur == '0) ? dv : fac_cur;
        gb <= dv;
        gk <= '0;
      end
      // Pull out the common powers of two.
      S_GSTRIP: begin
        if (!ga[0] && !gb[0]) begin
          ga <= ga >> 1;
          gb <= gb >> 1;
          gk <= gk + 5'd1;
        end
      end
      // Odd-odd subtract loop; the smaller operand is kept in gb.
      S_GLOOP: begin
        if (!ga[0]) begin
          ga <= ga >> 1;
        end else if (!gb[0]) begin
          gb <= gb >> 1;
        end else if (alu_zero) begin
          dvsr <= ga << gk;
          q    <= {fac_cur, {(MS_W-FRAME_W){1'b0}}};
          rem  <= '0;
          cnt  <= 6'd32;
        end else if (alu_c) begin
          ga <= alu_r[FRAME_W-1:0];
        end else begin
          ga <= gb;
          gb <= ga;
        end
      end
      // Reduce the current factor by the gcd.
      S_DIVF: begin
        if (cnt == 6'd1) begin
          fac[idx] <= q_next[FRAME_W-1:0];
          q        <= {dv, {(MS_W-FRAME_W){1'b0}}};
          rem      <= '0;
          cnt      <= 6'd32;
        end else begin
          q   <= q_next;
          rem <= rem_next;
          cnt <= cnt - 6'd1;
        end
      end
      // Reduce the running divisor by the same gcd.
      S_DIVD: begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          dv <= q_next[FRAME_W-1:0];
          if (idx == 2'd2) begin
            idx  <= 2'd0;
            prod <= MS_W'(1);
          end else begin
            idx <= idx + 2'd1;
          end
        end
      end
      S_MSTART: begin
        mreg <= fac_cur;
        acc  <= '0;
        cnt  <= 6'd32;
      end
      // Shift-add multiply, most significant multiplier bit first.
      S_MUL: begin
        acc  <= alu_r[MS_W-1:0];
        mreg <= mreg << 1;
        if (mul_ovf) begin
          res <= '0;
          cnt <= cnt - 6'd1;
        end else if (cnt == 6'd1) begin
          prod <= alu_r[MS_W-1:0];
          if (idx == 2'd2) begin
            q    <= alu_r[MS_W-1:0];
            rem  <= '0;
            dvsr <= dv;
            cnt  <= 6'd63;
          end else begin
            idx <= idx + 2'd1;
            cnt <= cnt - 6'd1;
          end
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
      // Final division of the product by the reduced divisor.
      S_DIVP: begin
        q   <= q_next;
        rem <= rem_next;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          res.ms <= q_next;
          res.ok <= 1'b1;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign done   = (state == S_DONE);
  assign result = res;

endmodule

// ===== hw/rtl/frame_to_millisecond_mapper.sv =====
// Frame-to-millisecond mapper: converts a frame index to milliseconds at a
// configured rational frame rate and clamps a requested position to the
// frame time of the configured last frame.
//
// Input channel: frame_index and requested_ms with in_valid / in_stall. One
// request is taken at a time; in_stall is high while a request is converted.
// Output channel: frame_ms, frame_ms_valid, clamped_ms and clamped_valid with
// out_valid / out_stall, held in an output register. A finished result waits
// there while the next request is accepted and converted.
// Each request runs two conversions on one shared adder, each with three
// binary gcd loops, three 32-step multiplies and a 63-step division. The
// time a request takes is set mostly by the gcd loops and the bit-serial
// divider; a conversion with a zero rate register skips all of them.
// Configuration: cfg_write, cfg_index and cfg_data write the rate numerator,
// rate denominator and last frame; other indexes are ignored. Write only while
// the block is idle.
// Reset (rst, synchronous) restores a 30/1 rate and last frame zero and
// empties the output register. When the receiver stalls, the result holds
// and no further result is written over it.
module frame_to_millisecond_mapper #(
  parameter int unsigned TIME_SCALE = 1000
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [ftm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ftm_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [ftm_pkg::FRAME_W-1:0]       frame_index,
  input  logic signed [ftm_pkg::REQ_W-1:0]  requested_ms,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [ftm_pkg::MS_W-1:0]          frame_ms,
  output logic                              frame_ms_valid,
  output logic [ftm_pkg::MS_W-1:0]          clamped_ms,
  output logic                              clamped_valid
);
  import ftm_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_FRAME = 4'b0010,
    T_BOUND = 4'b0100,
    T_OUT   = 4'b1000
  } top_state_t;

  top_state_t          state;
  logic                conv_start;
  logic [FRAME_W-1:0]  frame_hold;
  logic [REQ_W-1:0]    req_hold;
  conv_result_t        fres;
  conv_result_t        bres;

  logic [CFG_W-1:0]    rate_numerator;
  logic [CFG_W-1:0]    rate_denominator;
  logic [CFG_W-1:0]    last_frame;

  logic                in_take;
  logic                out_free;
  logic [FRAME_W-1:0]  conv_frame;
  logic                conv_done;
  conv_result_t        conv_res;
  logic [MS_W-1:0]     clamp_val;

  assign in_stall   = (state != T_IDLE);
  assign in_take    = in_valid && !in_stall;
  assign out_free   = !out_valid || !out_stall;
  assign conv_frame = (state == T_BOUND) ? last_frame : frame_hold;

  ftm_conv #(
    .TIME_SCALE (TIME_SCALE)
  ) u_conv (
    .clk      (clk),
    .rst      (rst),
    .start    (conv_start),
    .frame    (conv_frame),
    .rate_num (rate_numerator),
    .rate_den (rate_denominator),
    .done     (conv_done),
    .result   (conv_res)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rate_numerator   <= CFG_W'(30);
      rate_denominator <= CFG_W'(1);
      last_frame       <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_RATE_NUM:   rate_numerator   <= cfg_data;
        CFG_RATE_DEN:   rate_denominator <= cfg_data;
        CFG_LAST_FRAME: last_frame       <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Clamp the request to zero through the last frame time.
  always_comb begin
    priority if (!bres.ok) begin
      clamp_val = '0;
    end else if (req_hold[REQ_W-1]) begin
      clamp_val = '0;
    end else if (req_hold[MS_W-1:0] > bres.ms) begin
      clamp_val = bres.ms;
    end else begin
      clamp_val = req_hold[MS_W-1:0];
    end
  end

  // Request sequencing: frame conversion, then bound conversion.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= T_IDLE;
      conv_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      conv_start <= (state == T_IDLE && in_take) || (state == T_FRAME && conv_done);
      out_valid  <= (state == T_OUT && out_free) || (out_valid && out_stall);
      unique case (state)
        T_IDLE: begin
          if (in_take) begin
            state <= T_FRAME;
          end
        end
        T_FRAME: begin
          if (conv_done) begin
            state <= T_BOUND;
          end
        end
        T_BOUND: begin
          if (conv_done) begin
            state <= T_OUT;
          end
        end
        T_OUT: begin
          if (out_free) begin
            state <= T_IDLE;
          end
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  // Request and result holding registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      frame_hold <= frame_index;
      req_hold   <= requested_ms;
    end
    if (state == T_FRAME && conv_done) begin
      fres <= conv_res;
    end
    if (state == T_BOUND && conv_done) begin
      bres <= conv_res;
    end
    if (state == T_OUT && out_free) begin
      frame_ms       <= fres.ms;
      frame_ms_valid <= fres.ok;
      clamped_ms     <= clamp_val;
      clamped_valid  <= bres.ok;
    end
  end

endmodule
